// ===== rtl/dhlt_pkg.sv =====
// dhlt_pkg: item types, fixed-point constants and pipeline depths for the
// DH link transform. Used by dhlt_sincos, dh_link_transform and dhlt_checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dhlt_pkg;

    localparam int unsigned ANGLE_W = 16;   // Q3.13 angle
    localparam int unsigned LEN_W   = 32;   // Q16.16 length
    localparam int unsigned TRIG_W  = 16;   // Q2.14 rotation entry

    // Internal Q.29 datapath widths
    localparam int unsigned FRAC_W = 29;              // fraction bits
    localparam int unsigned U_W    = 30;              // |z| after reduction
    localparam int unsigned S_W    = 31;              // z^2 and each Horner quotient
    localparam int unsigned T_W    = 30;              // Horner term, 0 .. 1.0

    localparam logic [T_W-1:0]      ONE_Q29     = 30'h2000_0000;
    localparam logic [31:0]         PI_Q29      = 32'd1686629713;
    localparam logic signed [31:0]  HALF_PI_Q29 = 32'sd843314857;
    localparam logic signed [31:0]  NHALF_PI_Q29 = -32'sd843314857;

    // Horner divisors k*(k-1), innermost first
    localparam int unsigned COS_STEPS = 7;
    localparam int unsigned SIN_STEPS = 6;
    localparam int unsigned COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};
    localparam int unsigned SIN_DIV [SIN_STEPS] = '{156, 110, 72, 42, 20, 6};

    // sincos latency: reduce, square, two stages per cosine step, sine product, round
    localparam int unsigned SC_LAT = 2 + 2 * COS_STEPS + 2;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] joint_angle;
        logic signed [LEN_W-1:0]   link_offset;
        logic signed [LEN_W-1:0]   link_length;
        logic signed [ANGLE_W-1:0] link_twist;
    } t_dhlt_in;

    typedef struct packed {
        logic signed [TRIG_W-1:0] rot_00;
        logic signed [TRIG_W-1:0] rot_01;
        logic signed [TRIG_W-1:0] rot_02;
        logic signed [TRIG_W-1:0] rot_10;
        logic signed [TRIG_W-1:0] rot_11;
        logic signed [TRIG_W-1:0] rot_12;
        logic signed [TRIG_W-1:0] rot_20;
        logic signed [TRIG_W-1:0] rot_21;
        logic signed [TRIG_W-1:0] rot_22;
        logic signed [LEN_W-1:0]  trans_x;
        logic signed [LEN_W-1:0]  trans_y;
        logic signed [LEN_W-1:0]  trans_z;
    } t_dhlt_out;

endpackage

`default_nettype wire

// ===== rtl/dh_link_transform.sv =====
// dh_link_transform: Denavit-Hartenberg link transform, one link per item.
// Depends on dhlt_pkg and dhlt_sincos (two instances: theta and alpha).
//
// Usage notes
//  - Input channel: i_valid / o_stall / i_data (t_dhlt_in). An item is taken
//    on a rising edge with i_valid high and o_stall low.
//  - Output channel: o_valid / i_stall / o_data (t_dhlt_out), twelve entries
//    of the 4x4 transform; the constant bottom row is not sent.
//  - Throughput: one item per cycle while o_stall is low.
//  - Pipeline from the accepting edge to o_valid: input register,
//    18 stages of sine/cosine (fold, square, seven two-stage Horner steps,
//    sine product, rounding), one stage of products, then the output register.
//  - Stall: the output register is backed by a one-item skid entry. The
//    pipeline keeps moving while the output waits; once the skid entry is
//    occupied o_stall rises and the whole pipeline holds until the output
//    is taken.
//  - Reset (i_rst_n low, synchronous): clears all valid bits, those of the
//    output and skid entries too. Outside reset no item is lost once accepted.
//  - Translation x and y saturate to the 32-bit signed range.
`timescale 1ns / 1ps
`default_nettype none

module dh_link_transform import dhlt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_dhlt_in  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_dhlt_out o_data
);

    localparam int unsigned PIPE_N = SC_LAT + 2;  // input reg .. product stage

    typedef struct packed {
        logic signed [LEN_W-1:0] link_offset;
        logic signed [LEN_W-1:0] link_length;
    } t_dhlt_len;

    // Q2.14 x Q2.14 magnitude, rounded half up, then signed
    function automatic logic [TRIG_W-1:0] rnd_rot(input logic [2*TRIG_W-3:0] p,
                                                  input logic neg);
        logic [TRIG_W-1:0] m;
        m = TRIG_W'((31'(p) + 31'd8192) >> 14);
        return neg ? (TRIG_W'(0) - m) : m;
    endfunction

    // Q16.16 x Q2.14 magnitude, rounded, signed, saturated
    function automatic logic [LEN_W-1:0] rnd_trans(input logic [LEN_W+TRIG_W-2:0] p,
                                                   input logic neg);
        logic [LEN_W-1:0] m;
        m = LEN_W'((48'(p) + 48'd8192) >> 14);
        if (neg) begin
            return LEN_W'(0) - m;
        end
        return m[LEN_W-1] ? 32'h7FFF_FFFF : m;
    endfunction

    // global advance: the pipeline holds only when the skid entry is full
    logic en;
    logic r_skid_v;
    logic r_out_v;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign o_valid = r_out_v;

    // valid bits
    logic [PIPE_N-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_N-2:0], i_valid};
        end
    end

    // input register and length delay line
    t_dhlt_in  r_in;
    t_dhlt_len r_len [SC_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_data;
            r_len[0] <= {r_in.link_offset, r_in.link_length};
            for (int k = 1; k < SC_LAT; k++) begin
                r_len[k] <= r_len[k-1];
            end
        end
    end

    // sine and cosine of theta and alpha
    logic signed [TRIG_W-1:0] st;
    logic signed [TRIG_W-1:0] ct;
    logic signed [TRIG_W-1:0] sa;
    logic signed [TRIG_W-1:0] ca;

    dhlt_sincos u_theta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_in.joint_angle),
        .o_sin   (st),
        .o_cos   (ct)
    );

    dhlt_sincos u_alpha (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_in.link_twist),
        .o_sin   (sa),
        .o_cos   (ca)
    );

    // product stage: unsigned magnitudes, signs kept aside
    logic [TRIG_W-2:0] st_m;
    logic [TRIG_W-2:0] ct_m;
    logic [TRIG_W-2:0] sa_m;
    logic [TRIG_W-2:0] ca_m;
    logic [LEN_W-1:0]  a_m;
    t_dhlt_len         len_d;

    assign len_d = r_len[SC_LAT-1];
    assign st_m  = st[TRIG_W-1] ? (TRIG_W-1)'(-st) : (TRIG_W-1)'(st);
    assign ct_m  = ct[TRIG_W-1] ? (TRIG_W-1)'(-ct) : (TRIG_W-1)'(ct);
    assign sa_m  = sa[TRIG_W-1] ? (TRIG_W-1)'(-sa) : (TRIG_W-1)'(sa);
    assign ca_m  = ca[TRIG_W-1] ? (TRIG_W-1)'(-ca) : (TRIG_W-1)'(ca);
    assign a_m   = len_d.link_length[LEN_W-1] ? (LEN_W'(0) - len_d.link_length)
                                              : len_d.link_length;

    logic [2*TRIG_W-3:0]     r_p01;
    logic [2*TRIG_W-3:0]     r_p02;
    logic [2*TRIG_W-3:0]     r_p11;
    logic [2*TRIG_W-3:0]     r_p12;
    logic [LEN_W+TRIG_W-2:0] r_px;
    logic [LEN_W+TRIG_W-2:0] r_py;
    logic                    r_n01;
    logic                    r_n02;
    logic                    r_n11;
    logic                    r_n12;
    logic                    r_nx;
    logic                    r_ny;
    logic signed [TRIG_W-1:0] r_st;
    logic signed [TRIG_W-1:0] r_ct;
    logic signed [TRIG_W-1:0] r_sa;
    logic signed [TRIG_W-1:0] r_ca;
    logic signed [LEN_W-1:0]  r_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p01 <= st_m * ca_m;
            r_p02 <= st_m * sa_m;
            r_p11 <= ct_m * ca_m;
            r_p12 <= ct_m * sa_m;
            r_px  <= a_m * ct_m;
            r_py  <= a_m * st_m;
            // entries 01 and 12 carry an extra minus
            r_n01 <= !(st[TRIG_W-1] ^ ca[TRIG_W-1]);
            r_n02 <= st[TRIG_W-1] ^ sa[TRIG_W-1];
            r_n11 <= ct[TRIG_W-1] ^ ca[TRIG_W-1];
            r_n12 <= !(ct[TRIG_W-1] ^ sa[TRIG_W-1]);
            r_nx  <= len_d.link_length[LEN_W-1] ^ ct[TRIG_W-1];
            r_ny  <= len_d.link_length[LEN_W-1] ^ st[TRIG_W-1];
            r_st  <= st;
            r_ct  <= ct;
            r_sa  <= sa;
            r_ca  <= ca;
            r_d   <= len_d.link_offset;
        end
    end

    // rounding and assembly into the result item
    t_dhlt_out n_item;
    logic      inc;

    assign inc = r_vld[PIPE_N-1] && en;

    always_comb begin
        n_item.rot_00  = r_ct;
        n_item.rot_01  = rnd_rot(r_p01, r_n01);
        n_item.rot_02  = rnd_rot(r_p02, r_n02);
        n_item.rot_10  = r_st;
        n_item.rot_11  = rnd_rot(r_p11, r_n11);
        n_item.rot_12  = rnd_rot(r_p12, r_n12);
        n_item.rot_20  = '0;
        n_item.rot_21  = r_sa;
        n_item.rot_22  = r_ca;
        n_item.trans_x = rnd_trans(r_px, r_nx);
        n_item.trans_y = rnd_trans(r_py, r_ny);
        n_item.trans_z = r_d;
    end

    // output register with one skid entry
    t_dhlt_out r_out;
    t_dhlt_out r_skid;

    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            r_out_v  <= r_skid_v || inc;
            r_skid_v <= 1'b0;
        end else if (inc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : n_item;
        end else if (inc) begin
            r_skid <= n_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dhlt_sincos.sv =====
// dhlt_sincos: pipelined sine/cosine of a Q3.13 angle, Q2.14 results.
// Quadrant fold, then Horner polynomials with reciprocal-multiply division.
// Depends on dhlt_pkg. All stages advance only when i_en is high.
`timescale 1ns / 1ps
`default_nettype none

module dhlt_sincos import dhlt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [ANGLE_W-1:0] i_angle,
    output logic signed [TRIG_W-1:0]  o_sin,
    output logic signed [TRIG_W-1:0]  o_cos
);

    typedef struct packed {
        logic [S_W-1:0] s;
        logic [U_W-1:0] u;
        logic           zneg;
        logic           flip;
    } t_sc_ctl;

    // fold into [-pi/2, pi/2]
    logic signed [31:0] z;
    logic               red_hi;
    logic               red_lo;
    logic [32:0]        z_red;
    logic [32:0]        z_mag;

    assign z      = {i_angle, 16'h0000};
    assign red_hi = z > HALF_PI_Q29;
    assign red_lo = z < NHALF_PI_Q29;

    always_comb begin
        z_red = {z[31], z};
        if (red_hi) begin
            z_red = {z[31], z} - {1'b0, PI_Q29};
        end else if (red_lo) begin
            z_red = {z[31], z} + {1'b0, PI_Q29};
        end
        z_mag = z_red[32] ? (33'd0 - z_red) : z_red;
    end

    logic [U_W-1:0] r_u1;
    logic           r_zneg1;
    logic           r_flip1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u1    <= z_mag[U_W-1:0];
            r_zneg1 <= z_red[32];
            r_flip1 <= red_hi | red_lo;
        end
    end

    // s = u^2 in Q.29
    logic [2*U_W-1:0] uu;
    t_sc_ctl          r_ctl2;

    assign uu = r_u1 * r_u1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl2.s    <= uu[FRAC_W+S_W-1:FRAC_W];
            r_ctl2.u    <= r_u1;
            r_ctl2.zneg <= r_zneg1;
            r_ctl2.flip <= r_flip1;
        end
    end

    // Horner steps: stage a forms (s*t)>>29, stage b divides and subtracts from one
    t_sc_ctl        r_ctl_a [COS_STEPS];
    t_sc_ctl        r_ctl_b [COS_STEPS];
    logic [S_W-1:0] r_qc    [COS_STEPS];
    logic [T_W-1:0] r_tc    [COS_STEPS];
    logic [S_W-1:0] r_qs    [SIN_STEPS];
    logic [T_W-1:0] r_ts    [SIN_STEPS];

    for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
        localparam int unsigned CDiv   = COS_DIV[j];
        localparam int unsigned ShC    = S_W + $clog2(CDiv);
        localparam logic [31:0] RecipC =
            32'(((64'd1 << ShC) + 64'(CDiv) - 64'd1) / 64'(CDiv));

        t_sc_ctl            ctl_in;
        logic [T_W-1:0]     tc_in;
        logic [S_W+T_W-1:0] pc;
        logic [S_W+31:0]    ec_full;
        logic [S_W-1:0]     ec;

        if (j == 0) begin : g_first
            assign ctl_in = r_ctl2;
            assign tc_in  = ONE_Q29;
        end else begin : g_next
            assign ctl_in = r_ctl_b[j-1];
            assign tc_in  = r_tc[j-1];
        end

        assign pc      = ctl_in.s * tc_in;
        assign ec_full = r_qc[j] * RecipC;
        assign ec      = S_W'(ec_full >> ShC);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl_a[j] <= ctl_in;
                r_qc[j]    <= pc[FRAC_W+S_W-1:FRAC_W];
                r_ctl_b[j] <= r_ctl_a[j];
                // clamp at zero: only the last cosine term can go negative
                r_tc[j]    <= (ec >= S_W'(ONE_Q29)) ? '0 : T_W'(S_W'(ONE_Q29) - ec);
            end
        end

        // sine runs one step shorter, aligned to end with the cosine
        if (j >= 1) begin : g_sin
            localparam int unsigned SDiv   = SIN_DIV[j-1];
            localparam int unsigned ShS    = S_W + $clog2(SDiv);
            localparam logic [31:0] RecipS =
                32'(((64'd1 << ShS) + 64'(SDiv) - 64'd1) / 64'(SDiv));

            logic [T_W-1:0]     ts_in;
            logic [S_W+T_W-1:0] ps;
            logic [S_W+31:0]    es_full;
            logic [S_W-1:0]     es;

            if (j == 1) begin : g_sfirst
                assign ts_in = ONE_Q29;
            end else begin : g_snext
                assign ts_in = r_ts[j-2];
            end

            assign ps      = ctl_in.s * ts_in;
            assign es_full = r_qs[j-1] * RecipS;
            assign es      = S_W'(es_full >> ShS);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_qs[j-1] <= ps[FRAC_W+S_W-1:FRAC_W];
                    r_ts[j-1] <= (es >= S_W'(ONE_Q29)) ? '0 : T_W'(S_W'(ONE_Q29) - es);
                end
            end
        end
    end

    // sine = u * t
    logic [U_W+T_W-1:0] us;
    logic [U_W-1:0]     r_sv;
    logic [T_W-1:0]     r_cv;
    logic               r_zneg_f;
    logic               r_flip_f;

    assign us = r_ctl_b[COS_STEPS-1].u * r_ts[SIN_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sv     <= us[FRAC_W+U_W-1:FRAC_W];
            r_cv     <= r_tc[COS_STEPS-1];
            r_zneg_f <= r_ctl_b[COS_STEPS-1].zneg;
            r_flip_f <= r_ctl_b[COS_STEPS-1].flip;
        end
    end

    // round Q.29 to Q.14, half away from zero, then sign
    logic [TRIG_W-1:0] sin_mag;
    logic [TRIG_W-1:0] cos_mag;

    assign sin_mag = TRIG_W'((31'(r_sv) + 31'd16384) >> 15);
    assign cos_mag = TRIG_W'((31'(r_cv) + 31'd16384) >> 15);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= (r_zneg_f ^ r_flip_f) ? (TRIG_W'(0) - sin_mag) : sin_mag;
            o_cos <= r_flip_f ? (TRIG_W'(0) - cos_mag) : cos_mag;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dhlt_checker.sv =====
// dhlt_checker: port-level assertions for dh_link_transform, bound to it.
// Depends on dhlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dhlt_checker import dhlt_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_valid,
    input wire logic      o_stall,
    input wire logic      i_stall,
    input wire t_dhlt_out o_data
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result item changed while stalled");

    // bottom-left rotation entry is constant zero
    a_rot20_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.rot_20 == '0)
        else $error("rot_20 not zero");

    // cos and sin of theta stay within +-1.0
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.rot_00 <= 16'sd16384) && (o_data.rot_00 >= -16'sd16384)
                 && (o_data.rot_10 <= 16'sd16384) && (o_data.rot_10 >= -16'sd16384))
        else $error("theta sine or cosine out of range");

    // back-pressure only builds up behind a stalled result item
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid) && $past(i_stall))
        else $error("input stalled without a stalled result item");

    // reset empties the output side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not cleared by reset");

endmodule

bind dh_link_transform dhlt_checker u_dhlt_checker (.*);

`default_nettype wire
